/* rtl/bmhq_pkg.sv */
// Shared types and constants for the binary min-heap queue unit.
// No dependencies; every other file refers to it by scoped names.
package bmhq_pkg;

  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_RM_ROOT,
    S_RM_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_FIN
  } state_t;

endpackage

/* rtl/bmhq_ifs.sv */
// Valid/ready channel interfaces for the heap queue: request and result.
// Depends on bmhq_pkg for field widths.
interface bmhq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic signed [bmhq_pkg::KEY_W-1:0]    key;
  logic        [bmhq_pkg::PAY_W-1:0]    payload;

  modport source (output valid, output op, output key, output payload, input ready);
  modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface bmhq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [bmhq_pkg::STATUS_W-1:0]        status;
  logic [bmhq_pkg::PAY_W-1:0]           min_payload;
  logic [bmhq_pkg::CNT_OUT_W-1:0]       count;

  modport source (output valid, output status, output min_payload, output count,
                  input ready);
  modport sink   (input valid, input status, input min_payload, input count,
                  output ready);
endinterface

/* rtl/binary_min_heap_queue_unit.sv */
// Binary min-heap priority queue: one entry memory, one key comparator, sequencer.
// Depends on bmhq_pkg and the channel interfaces in bmhq_ifs.sv.
//
// Each request is either an insert (key, payload) or a remove of the entry with the
// smallest signed key; every request gives exactly one result with status, removed
// payload and entry count. The block takes one request at a time: ready is high
// only while the sequencer is idle. An insert places its entry last and sifts it up,
// reading the parent in S_UP_CHK and comparing and writing in S_UP_CMP per level. A
// remove reads the root (S_RM_ROOT) and the last entry (S_RM_LAST), then, unless the
// heap is empty, sifts down via S_DN_CHK, S_DN_L and, if a right child exists, S_DN_R
// per level; a sift covers at most ceil(log2(CAPACITY)) levels, 6 at 64 entries. The
// steps follow from the single memory read port, whose data is registered, and the one shared
// comparator. Full-heap inserts and empty-heap removes go from idle straight to the
// final state. The sequencer is back in idle in the cycle after it loads a result, and
// takes the next request while that result waits in an output register; the following
// result holds the sequencer in its final state until that register is free.
module binary_min_heap_queue_unit #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst,
  bmhq_req_if.sink        item,
  bmhq_rsp_if.source      result
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = ADDR_W + 2;

  // entry memory
  bmhq_pkg::entry_t mem [CAPACITY];
  bmhq_pkg::entry_t rd_data;
  bmhq_pkg::entry_t wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  bmhq_pkg::state_t state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] pos, pos_next;
  bmhq_pkg::entry_t  cur, cur_next;
  bmhq_pkg::entry_t  child, child_next;
  logic              left_win, left_win_next;
  logic [bmhq_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [bmhq_pkg::PAY_W-1:0]    res_min, res_min_next;

  logic                          out_valid;
  logic [bmhq_pkg::STATUS_W-1:0] out_status;
  logic [bmhq_pkg::PAY_W-1:0]    out_min;
  logic [CNT_W-1:0]              out_count;
  logic                          out_load;

  logic signed [bmhq_pkg::KEY_W-1:0] cmp_a, cmp_b;
  logic                              less;
  logic [ADDR_W-1:0] pos_m1, parent;
  logic [IDX_W-1:0]  l_idx, r_idx, count_idx;
  logic              l_ok, r_ok, full, in_acc;
  logic [CNT_W+bmhq_pkg::CNT_OUT_W-1:0] count_wide;

  assign in_acc    = item.valid && item.ready;
  assign full      = (count == CNT_W'(CAPACITY));
  assign pos_m1    = pos - 1'b1;
  assign parent    = ADDR_W'(pos_m1 >> 1);
  assign l_idx     = {1'b0, pos, 1'b1};
  assign r_idx     = l_idx + 1'b1;
  assign count_idx = IDX_W'(count);
  assign l_ok      = l_idx < count_idx;
  assign r_ok      = r_idx < count_idx;
  assign less      = cmp_a < cmp_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmhq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    pos        <= pos_next;
    cur        <= cur_next;
    child      <= child_next;
    left_win   <= left_win_next;
    res_status <= res_status_next;
    res_min    <= res_min_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    cur_next        = cur;
    child_next      = child;
    left_win_next   = left_win;
    res_status_next = res_status;
    res_min_next    = res_min;
    rd_addr         = pos;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = cur;
    cmp_a           = rd_data.key;
    cmp_b           = cur.key;
    item.ready      = 1'b0;
    out_load        = 1'b0;

    unique case (state)
      bmhq_pkg::S_IDLE: begin
        item.ready = 1'b1;
        if (in_acc) begin
          res_status_next = bmhq_pkg::ST_DONE;
          res_min_next    = '0;
          if (item.op == bmhq_pkg::OP_INSERT) begin
            if (full) begin
              res_status_next = bmhq_pkg::ST_FULL;
              state_next      = bmhq_pkg::S_FIN;
            end else begin
              cur_next   = '{key: item.key, payload: item.payload};
              pos_next   = ADDR_W'(count);
              count_next = count + 1'b1;
              state_next = bmhq_pkg::S_UP_CHK;
            end
          end else if (count == '0) begin
            res_status_next = bmhq_pkg::ST_EMPTY;
            state_next      = bmhq_pkg::S_FIN;
          end else begin
            rd_addr    = '0;
            state_next = bmhq_pkg::S_RM_ROOT;
          end
        end
      end

      bmhq_pkg::S_UP_CHK: begin
        rd_addr = parent;
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = bmhq_pkg::S_FIN;
        end else begin
          state_next = bmhq_pkg::S_UP_CMP;
        end
      end

      bmhq_pkg::S_UP_CMP: begin
        // parent sits in rd_data; move it down a level if the new key is smaller
        cmp_a = cur.key;
        cmp_b = rd_data.key;
        wr_en = 1'b1;
        if (less) begin
          wr_data    = rd_data;
          pos_next   = parent;
          state_next = bmhq_pkg::S_UP_CHK;
        end else begin
          state_next = bmhq_pkg::S_FIN;
        end
      end

      bmhq_pkg::S_RM_ROOT: begin
        res_min_next = rd_data.payload;
        rd_addr      = ADDR_W'(count - 1'b1);
        count_next   = count - 1'b1;
        state_next   = bmhq_pkg::S_RM_LAST;
      end

      bmhq_pkg::S_RM_LAST: begin
        cur_next   = rd_data;
        pos_next   = '0;
        state_next = (count == '0) ? bmhq_pkg::S_FIN : bmhq_pkg::S_DN_CHK;
      end

      bmhq_pkg::S_DN_CHK: begin
        rd_addr = l_idx[ADDR_W-1:0];
        if (l_ok) begin
          state_next = bmhq_pkg::S_DN_L;
        end else begin
          wr_en      = 1'b1;
          state_next = bmhq_pkg::S_FIN;
        end
      end

      bmhq_pkg::S_DN_L: begin
        // left child in rd_data; right child read issued now
        rd_addr = r_idx[ADDR_W-1:0];
        if (r_ok) begin
          left_win_next = less;
          child_next    = rd_data;
          state_next    = bmhq_pkg::S_DN_R;
        end else begin
          wr_en = 1'b1;
          if (less) begin
            wr_data    = rd_data;
            pos_next   = l_idx[ADDR_W-1:0];
            state_next = bmhq_pkg::S_DN_CHK;
          end else begin
            state_next = bmhq_pkg::S_FIN;
          end
        end
      end

      bmhq_pkg::S_DN_R: begin
        // right child must be strictly smaller than the current best to win
        cmp_b = left_win ? child.key : cur.key;
        wr_en = 1'b1;
        if (less) begin
          wr_data    = rd_data;
          pos_next   = r_idx[ADDR_W-1:0];
          state_next = bmhq_pkg::S_DN_CHK;
        end else if (left_win) begin
          wr_data    = child;
          pos_next   = l_idx[ADDR_W-1:0];
          state_next = bmhq_pkg::S_DN_CHK;
        end else begin
          state_next = bmhq_pkg::S_FIN;
        end
      end

      bmhq_pkg::S_FIN: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = bmhq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_status <= res_status;
      out_min    <= res_min;
      out_count  <= count;
    end
  end

  assign count_wide         = {{bmhq_pkg::CNT_OUT_W{1'b0}}, out_count};
  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.min_payload = out_min;
  assign result.count       = count_wide[bmhq_pkg::CNT_OUT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    in_acc && item.op == bmhq_pkg::OP_INSERT && !full |=> count == $past(count) + 1'b1)
    else $error("accepted insert did not add an entry");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == bmhq_pkg::S_IDLE || state == bmhq_pkg::S_FIN |-> !wr_en)
    else $error("memory written outside a sift");

  a_failed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != bmhq_pkg::ST_DONE |-> out_min == '0)
    else $error("failed request carries a payload");

endmodule
